[rtl/source_lexer_tokenizer_core_assert.svh]
// assertion macros shared by the lexer checker
`ifndef SOURCE_LEXER_TOKENIZER_CORE_ASSERT_SVH
`define SOURCE_LEXER_TOKENIZER_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SLTC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define SLTC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/sltc_pkg.sv]
// shared types, constants and character classes for the source lexer
package sltc_pkg;

    localparam int KEYWORD_SLOTS = 8;
    localparam int PREFIX_LEN    = 5;
    localparam int LEN_SAT       = 65535;
    localparam int LEN_W         = 16;
    localparam int PREFIX_IDX_W  = $clog2(PREFIX_LEN);
    localparam int KW_COUNT      = 8;
    localparam int KW_MAX        = 5;

    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);

    localparam int IN_TDATA_W    = 8;
    localparam int OUT_TDATA_W   = 40;
    localparam int OUT_TUSER_W   = 3;

    typedef enum logic [2:0] {
        KIND_IDENT   = 3'd0,
        KIND_KEYWORD = 3'd1,
        KIND_NUMBER  = 3'd2,
        KIND_OPER    = 3'd3,
        KIND_STRING  = 3'd4,
        KIND_ERROR   = 3'd5
    } kind_t;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0a;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_STAR  = 8'h2a;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_EQ    = 8'h3d;
    localparam logic [7:0] CH_BSL   = 8'h5c;

    localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX] = '{
        '{"i", "f", 8'd0, 8'd0, 8'd0},
        '{"e", "l", "s", "e", 8'd0},
        '{"f", "o", "r", 8'd0, 8'd0},
        '{"w", "h", "i", "l", "e"},
        '{"d", "o", 8'd0, 8'd0, 8'd0},
        '{"i", "n", "t", 8'd0, 8'd0},
        '{"r", "e", "a", "d", 8'd0},
        '{"w", "r", "i", "t", "e"}
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd2, 3'd4, 3'd3, 3'd5, 3'd2, 3'd3, 3'd4, 3'd5
    };

    typedef struct packed {
        kind_t             kind;
        logic [2:0]        kw_idx;
        logic [7:0]        c1;
        logic [7:0]        c2;
        logic [LEN_W-1:0]  len;
        logic              last;
    } token_t;

    function automatic token_t mk_tok(kind_t kind, logic [2:0] kw, logic [7:0] c1,
                                      logic [7:0] c2, logic [LEN_W-1:0] len);
        token_t t;
        t.kind   = kind;
        t.kw_idx = kw;
        t.c1     = c1;
        t.c2     = c2;
        t.len    = len;
        t.last   = 1'b0;
        return t;
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_NL;
    endfunction

    function automatic logic is_oper(logic [7:0] c);
        return c == "+" || c == "-" || c == "*" || c == "(" || c == ")" ||
               c == "{" || c == "}" || c == ";" || c == "," || c == ":";
    endfunction

    function automatic logic is_cmp(logic [7:0] c);
        return c == ">" || c == "<" || c == "=" || c == "!";
    endfunction

endpackage

[rtl/source_lexer_tokenizer_core.sv]
// source lexer: character stream in, token stream out
//
// input channel s_axis: one source byte per transaction in tdata[7:0];
// tlast marks end of source, flushes a pending token and returns to idle
// (the byte is then ignored)
// output channel m_axis: one token per transaction; tuser holds the kind,
// tdata holds keyword index, first and second characters and length;
// tlast is set on the final token caused by one input byte
// an accepted byte passes the input register, then the token queue, from
// which its tokens are offered on the output channel
// throughput: one byte per cycle while the token queue has room; a byte that ends
// one token and is itself a one-character token costs two output transactions,
// set by the single output port; a four-entry token queue decouples the sides, so input
// is still taken while the receiver stalls, until the queue has less than two free slots
// reset: state returns to idle, token queue and input register are emptied
// no clearing pass is needed after reset
module source_lexer_tokenizer_core
    import sltc_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [IN_TDATA_W-1:0]   s_axis_tdata,   // ch[7:0]
    input  logic                    s_axis_tlast,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [OUT_TDATA_W-1:0]  m_axis_tdata,   // keyword_index[2:0], first_char[10:3],
                                                    // second_char[18:11], length[34:19]
    output logic [OUT_TUSER_W-1:0]  m_axis_tuser,   // kind[2:0]
    output logic                    m_axis_tlast
);

    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_NUMBER,
        MODE_CMP,
        MODE_SLASH,
        MODE_COMMENT,
        MODE_CSTAR,
        MODE_STRING,
        MODE_SESC,
        MODE_HALT
    } mode_t;

    // input register
    logic                   in_valid_reg, in_valid_next;
    logic [7:0]             in_ch_reg;
    logic                   in_last_reg;

    // lexer state
    mode_t                  mode_reg, mode_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic [7:0]             held_reg, held_next;
    logic [7:0]             prefix_reg [PREFIX_LEN];

    // token queue
    token_t                 fifo_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0]  cnt_reg, cnt_next;

    logic                   fire;
    logic                   s_accept;
    logic                   m_accept;
    token_t                 head;

    // current token view
    logic                   kw_hit;
    logic [2:0]             kw_idx;
    logic [7:0]             tok_c1;
    logic [7:0]             tok_c2;
    token_t                 word_tok;

    // per-byte decisions
    logic                   flush_v;
    token_t                 flush_tok;
    logic                   idle_go;
    logic                   idle_v;
    token_t                 idle_tok;
    logic                   add_c;
    logic                   restart;
    logic [LEN_W-1:0]       base_len;
    logic                   pre_we;
    logic [PREFIX_IDX_W-1:0] pre_idx;
    logic [1:0]             n_res;
    token_t                 r0;
    token_t                 r1;

    assign fire          = in_valid_reg && (cnt_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign s_axis_tready = !in_valid_reg || fire;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign in_valid_next = s_accept || (in_valid_reg && !fire);

    assign head          = fifo_reg[rd_ptr_reg];
    assign m_axis_tvalid = cnt_reg != '0;
    assign m_accept      = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata  = OUT_TDATA_W'({head.len, head.c2, head.c1, head.kw_idx});
    assign m_axis_tuser  = head.kind;
    assign m_axis_tlast  = head.last;

    // keyword compare, lowest slot wins
    always_comb begin
        logic m;
        kw_hit = 1'b0;
        kw_idx = 3'd0;
        for (int k = KEYWORD_SLOTS - 1; k >= 0; k--) begin
            m = (len_reg == LEN_W'(KW_LEN[k]));
            for (int i = 0; i < KW_MAX; i++) begin
                if (3'(i) < KW_LEN[k] && prefix_reg[i] != KW_TEXT[k][i]) begin
                    m = 1'b0;
                end
            end
            if (m) begin
                kw_hit = 1'b1;
                kw_idx = 3'(k);
            end
        end
    end

    assign tok_c1   = (len_reg >= LEN_W'(1)) ? prefix_reg[0] : 8'd0;
    assign tok_c2   = (len_reg >= LEN_W'(2)) ? prefix_reg[1] : 8'd0;
    assign word_tok = kw_hit ? mk_tok(KIND_KEYWORD, kw_idx, tok_c1, tok_c2, len_reg)
                             : mk_tok(KIND_IDENT, 3'd0, tok_c1, tok_c2, len_reg);

    always_comb begin
        mode_next = mode_reg;
        len_next  = len_reg;
        held_next = held_reg;
        flush_v   = 1'b0;
        flush_tok = mk_tok(KIND_IDENT, 3'd0, 8'd0, 8'd0, '0);
        idle_go   = 1'b0;
        idle_v    = 1'b0;
        idle_tok  = mk_tok(KIND_IDENT, 3'd0, 8'd0, 8'd0, '0);
        add_c     = 1'b0;
        restart   = 1'b0;
        base_len  = len_reg;
        pre_we    = 1'b0;
        pre_idx   = '0;

        if (in_last_reg) begin
            case (mode_reg)
                MODE_IDENT: begin
                    flush_v   = 1'b1;
                    flush_tok = word_tok;
                end
                MODE_NUMBER: begin
                    flush_v   = 1'b1;
                    flush_tok = mk_tok(KIND_NUMBER, 3'd0, tok_c1, tok_c2, len_reg);
                end
                MODE_CMP: begin
                    flush_v   = 1'b1;
                    flush_tok = mk_tok(KIND_OPER, 3'd0, held_reg, 8'd0, LEN_W'(1));
                end
                MODE_SLASH: begin
                    flush_v   = 1'b1;
                    flush_tok = mk_tok(KIND_OPER, 3'd0, CH_SLASH, 8'd0, LEN_W'(1));
                end
                MODE_STRING, MODE_SESC: begin
                    flush_v   = 1'b1;
                    flush_tok = mk_tok(KIND_ERROR, 3'd0, tok_c1, tok_c2, len_reg);
                end
                default: ;
            endcase
            mode_next = MODE_IDLE;
            len_next  = '0;
        end else begin
            case (mode_reg)
                MODE_IDENT: begin
                    if (is_alpha(in_ch_reg) || is_digit(in_ch_reg)) begin
                        add_c = 1'b1;
                    end else begin
                        flush_v   = 1'b1;
                        flush_tok = word_tok;
                        idle_go   = 1'b1;
                    end
                end
                MODE_NUMBER: begin
                    if (is_digit(in_ch_reg)) begin
                        add_c = 1'b1;
                    end else begin
                        flush_v   = 1'b1;
                        flush_tok = mk_tok(KIND_NUMBER, 3'd0, tok_c1, tok_c2, len_reg);
                        idle_go   = 1'b1;
                    end
                end
                MODE_CMP: begin
                    flush_v = 1'b1;
                    if (in_ch_reg == CH_EQ) begin
                        flush_tok = mk_tok(KIND_OPER, 3'd0, held_reg, CH_EQ, LEN_W'(2));
                        mode_next = MODE_IDLE;
                    end else begin
                        flush_tok = mk_tok(KIND_OPER, 3'd0, held_reg, 8'd0, LEN_W'(1));
                        idle_go   = 1'b1;
                    end
                end
                MODE_SLASH: begin
                    if (in_ch_reg == CH_STAR) begin
                        mode_next = MODE_COMMENT;
                    end else begin
                        flush_v   = 1'b1;
                        flush_tok = mk_tok(KIND_OPER, 3'd0, CH_SLASH, 8'd0, LEN_W'(1));
                        idle_go   = 1'b1;
                    end
                end
                MODE_COMMENT: begin
                    if (in_ch_reg == CH_STAR) begin
                        mode_next = MODE_CSTAR;
                    end
                end
                MODE_CSTAR: begin
                    if (in_ch_reg == CH_SLASH) begin
                        mode_next = MODE_IDLE;
                    end else if (in_ch_reg != CH_STAR) begin
                        mode_next = MODE_COMMENT;
                    end
                end
                MODE_STRING: begin
                    if (in_ch_reg == CH_QUOTE) begin
                        flush_v   = 1'b1;
                        flush_tok = mk_tok(KIND_STRING, 3'd0, tok_c1, tok_c2, len_reg);
                        mode_next = MODE_IDLE;
                    end else if (in_ch_reg == CH_BSL) begin
                        mode_next = MODE_SESC;
                    end else begin
                        add_c = 1'b1;
                    end
                end
                MODE_SESC: begin
                    add_c     = 1'b1;
                    mode_next = MODE_STRING;
                end
                MODE_HALT: ;
                default: begin
                    idle_go = 1'b1;
                end
            endcase
        end

        // a byte seen with the block idle, or the byte that ended the previous token
        if (idle_go) begin
            mode_next = MODE_IDLE;
            if (is_space(in_ch_reg)) begin
                mode_next = MODE_IDLE;
            end else if (is_alpha(in_ch_reg)) begin
                restart   = 1'b1;
                add_c     = 1'b1;
                mode_next = MODE_IDENT;
            end else if (is_digit(in_ch_reg)) begin
                restart   = 1'b1;
                add_c     = 1'b1;
                mode_next = MODE_NUMBER;
            end else if (is_oper(in_ch_reg)) begin
                idle_v   = 1'b1;
                idle_tok = mk_tok(KIND_OPER, 3'd0, in_ch_reg, 8'd0, LEN_W'(1));
            end else if (is_cmp(in_ch_reg)) begin
                held_next = in_ch_reg;
                mode_next = MODE_CMP;
            end else if (in_ch_reg == CH_SLASH) begin
                mode_next = MODE_SLASH;
            end else if (in_ch_reg == CH_QUOTE) begin
                len_next  = '0;
                mode_next = MODE_STRING;
            end else begin
                idle_v    = 1'b1;
                idle_tok  = mk_tok(KIND_ERROR, 3'd0, in_ch_reg, 8'd0, LEN_W'(1));
                mode_next = MODE_HALT;
            end
        end

        // append one character: store it in the prefix while there is room, count it in the length
        if (add_c) begin
            base_len = restart ? '0 : len_reg;
            if (base_len < LEN_W'(PREFIX_LEN)) begin
                pre_we  = 1'b1;
                pre_idx = base_len[PREFIX_IDX_W-1:0];
            end
            len_next = (base_len < LEN_W'(LEN_SAT)) ? base_len + LEN_W'(1) : base_len;
        end
    end

    always_comb begin
        if (flush_v) begin
            r0    = flush_tok;
            r1    = idle_tok;
            n_res = idle_v ? 2'd2 : 2'd1;
        end else begin
            r0    = idle_tok;
            r1    = idle_tok;
            n_res = idle_v ? 2'd1 : 2'd0;
        end
        r0.last = (n_res == 2'd1);
        r1.last = 1'b1;
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (fire) begin
            wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(n_res);
            cnt_next    = cnt_next + FIFO_CNT_W'(n_res);
        end
        if (m_accept) begin
            rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(1);
            cnt_next    = cnt_next - FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            mode_reg     <= MODE_IDLE;
            len_reg      <= '0;
            held_reg     <= 8'd0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            cnt_reg      <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            if (fire) begin
                mode_reg <= mode_next;
                len_reg  <= len_next;
                held_reg <= held_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_ch_reg   <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (fire && pre_we) begin
            prefix_reg[pre_idx] <= in_ch_reg;
        end
        if (fire && n_res != 2'd0) begin
            fifo_reg[wr_ptr_reg] <= r0;
        end
        if (fire && n_res == 2'd2) begin
            fifo_reg[wr_ptr_reg + FIFO_PTR_W'(1)] <= r1;
        end
    end

endmodule

[rtl/sltc_checker.sv]
// port-level checks for the source lexer and their binding
`include "source_lexer_tokenizer_core_assert.svh"

module sltc_checker
    import sltc_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    input  logic [OUT_TDATA_W-1:0]  m_axis_tdata,
    input  logic [OUT_TUSER_W-1:0]  m_axis_tuser,
    input  logic                    m_axis_tlast
);

    // a stalled token holds
    `SLTC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "token changed while stalled")

    // keyword index only on keywords
    `SLTC_ASSERT_NOW(a_kw_idx, m_axis_tvalid && m_axis_tuser != KIND_KEYWORD, m_axis_tdata[2:0] == 3'd0, "keyword index on non-keyword")

    // operators are one or two characters
    `SLTC_ASSERT_NOW(a_oper_len, m_axis_tvalid && m_axis_tuser == KIND_OPER, m_axis_tdata[34:19] == 16'd1 || m_axis_tdata[34:19] == 16'd2, "bad operator length")

    // keywords are two to five characters
    `SLTC_ASSERT_NOW(a_kw_len, m_axis_tvalid && m_axis_tuser == KIND_KEYWORD, m_axis_tdata[34:19] >= 16'd2 && m_axis_tdata[34:19] <= 16'd5, "bad keyword length")

endmodule

bind source_lexer_tokenizer_core sltc_checker u_sltc_checker (.*);

[test/lexer_token_checker.sv]
`timescale 1ns / 100ps
// token checker: predicts the lexer's token stream and compares it with the output channel
module lexer_token_checker
    import sltc_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_axis_tvalid,
    input  logic                    s_axis_tready,
    input  logic [IN_TDATA_W-1:0]   s_axis_tdata,
    input  logic                    s_axis_tlast,
    input  logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    input  logic [OUT_TDATA_W-1:0]  m_axis_tdata,
    input  logic [OUT_TUSER_W-1:0]  m_axis_tuser,
    input  logic                    m_axis_tlast,
    output int                      fail_count,
    output int                      tokens_pending,
    output int                      tokens_checked
);

    typedef enum logic [3:0] {
        LX_IDLE,
        LX_WORD,
        LX_DIGITS,
        LX_CMP,
        LX_SLASH,
        LX_COMMENT,
        LX_COMMENT_STAR,
        LX_STRING,
        LX_STRING_ESC,
        LX_HALT
    } lex_mode_t;

    localparam logic [2:0]  KW_IF    = 3'd0;
    localparam logic [2:0]  KW_ELSE  = 3'd1;
    localparam logic [2:0]  KW_FOR   = 3'd2;
    localparam logic [2:0]  KW_WHILE = 3'd3;
    localparam logic [2:0]  KW_DO    = 3'd4;
    localparam logic [2:0]  KW_INT   = 3'd5;
    localparam logic [2:0]  KW_READ  = 3'd6;
    localparam logic [2:0]  KW_WRITE = 3'd7;
    localparam logic [2:0]  KW_NONE  = 3'd0;
    localparam logic [15:0] TEXT_LEN_MAX = 16'hffff;
    localparam int          WORD_CHARS   = 5;

    lex_mode_t   lex_mode;
    logic [7:0]  text_head [PREFIX_LEN];
    logic [15:0] text_len;
    logic [7:0]  cmp_char;
    token_t      step_tokens [2];
    int          step_count;
    token_t      tokens_due [$];
    int          errors;
    int          checked;

    function automatic logic is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_numeral(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function void emit(kind_t k, logic [2:0] kw, logic [7:0] a, logic [7:0] b,
                       logic [15:0] n);
        if (step_count < 2) begin
            step_tokens[step_count] = '{kind: k, kw_idx: kw, c1: a, c2: b, len: n, last: 1'b0};
            step_count++;
        end
    endfunction

    function void take_char(logic [7:0] c);
        if (text_len < PREFIX_LEN) begin
            text_head[text_len[2:0]] = c;
        end
        if (text_len != TEXT_LEN_MAX) begin
            text_len = text_len + 16'd1;
        end
    endfunction

    function void emit_text(kind_t k, logic [2:0] kw);
        emit(k, kw, text_len >= 1 ? text_head[0] : 8'd0,
             text_len >= 2 ? text_head[1] : 8'd0, text_len);
    endfunction

    function void emit_word();
        logic [39:0] word;
        logic [2:0]  idx;
        logic        hit;
        word = '0;
        idx  = KW_NONE;
        hit  = 1'b0;
        for (int i = 0; i < WORD_CHARS && i < text_len; i++) begin
            word = {word[31:0], text_head[i]};
        end
        case (text_len)
            16'd2: begin
                if (word[15:0] == "if") begin
                    hit = 1'b1; idx = KW_IF;
                end else if (word[15:0] == "do") begin
                    hit = 1'b1; idx = KW_DO;
                end
            end
            16'd3: begin
                if (word[23:0] == "for") begin
                    hit = 1'b1; idx = KW_FOR;
                end else if (word[23:0] == "int") begin
                    hit = 1'b1; idx = KW_INT;
                end
            end
            16'd4: begin
                if (word[31:0] == "else") begin
                    hit = 1'b1; idx = KW_ELSE;
                end else if (word[31:0] == "read") begin
                    hit = 1'b1; idx = KW_READ;
                end
            end
            16'd5: begin
                if (word[39:0] == "while") begin
                    hit = 1'b1; idx = KW_WHILE;
                end else if (word[39:0] == "write") begin
                    hit = 1'b1; idx = KW_WRITE;
                end
            end
            default: ;
        endcase
        if (hit) begin
            emit_text(KIND_KEYWORD, idx);
        end else begin
            emit_text(KIND_IDENT, KW_NONE);
        end
    endfunction

    function void start_token(logic [7:0] c);
        lex_mode = LX_IDLE;
        if (c == CH_SPACE || c == CH_TAB || c == CH_NL) begin
            return;
        end
        if (is_letter(c)) begin
            text_len = '0;
            take_char(c);
            lex_mode = LX_WORD;
        end else if (is_numeral(c)) begin
            text_len = '0;
            take_char(c);
            lex_mode = LX_DIGITS;
        end else if (c == "+" || c == "-" || c == "*" || c == "(" || c == ")" ||
                     c == "{" || c == "}" || c == ";" || c == "," || c == ":") begin
            emit(KIND_OPER, KW_NONE, c, 8'd0, 16'd1);
        end else if (c == ">" || c == "<" || c == "=" || c == "!") begin
            cmp_char = c;
            lex_mode = LX_CMP;
        end else if (c == CH_SLASH) begin
            lex_mode = LX_SLASH;
        end else if (c == CH_QUOTE) begin
            text_len = '0;
            lex_mode = LX_STRING;
        end else begin
            emit(KIND_ERROR, KW_NONE, c, 8'd0, 16'd1);
            lex_mode = LX_HALT;
        end
    endfunction

    function void lex_step(logic [7:0] c, logic eoi);
        step_count = 0;
        if (eoi) begin
            case (lex_mode)
                LX_WORD: emit_word();
                LX_DIGITS: emit_text(KIND_NUMBER, KW_NONE);
                LX_CMP: emit(KIND_OPER, KW_NONE, cmp_char, 8'd0, 16'd1);
                LX_SLASH: emit(KIND_OPER, KW_NONE, CH_SLASH, 8'd0, 16'd1);
                LX_STRING, LX_STRING_ESC: emit_text(KIND_ERROR, KW_NONE);
                default: ;
            endcase
            lex_mode = LX_IDLE;
            text_len = '0;
        end else begin
            case (lex_mode)
                LX_WORD: begin
                    if (is_letter(c) || is_numeral(c)) begin
                        take_char(c);
                    end else begin
                        emit_word();
                        start_token(c);
                    end
                end
                LX_DIGITS: begin
                    if (is_numeral(c)) begin
                        take_char(c);
                    end else begin
                        emit_text(KIND_NUMBER, KW_NONE);
                        start_token(c);
                    end
                end
                LX_CMP: begin
                    if (c == CH_EQ) begin
                        emit(KIND_OPER, KW_NONE, cmp_char, CH_EQ, 16'd2);
                        lex_mode = LX_IDLE;
                    end else begin
                        emit(KIND_OPER, KW_NONE, cmp_char, 8'd0, 16'd1);
                        start_token(c);
                    end
                end
                LX_SLASH: begin
                    if (c == CH_STAR) begin
                        lex_mode = LX_COMMENT;
                    end else begin
                        emit(KIND_OPER, KW_NONE, CH_SLASH, 8'd0, 16'd1);
                        start_token(c);
                    end
                end
                LX_COMMENT: begin
                    if (c == CH_STAR) begin
                        lex_mode = LX_COMMENT_STAR;
                    end
                end
                LX_COMMENT_STAR: begin
                    if (c == CH_SLASH) begin
                        lex_mode = LX_IDLE;
                    end else if (c != CH_STAR) begin
                        lex_mode = LX_COMMENT;
                    end
                end
                LX_STRING: begin
                    if (c == CH_QUOTE) begin
                        emit_text(KIND_STRING, KW_NONE);
                        lex_mode = LX_IDLE;
                    end else if (c == CH_BSL) begin
                        lex_mode = LX_STRING_ESC;
                    end else begin
                        take_char(c);
                    end
                end
                LX_STRING_ESC: begin
                    take_char(c);
                    lex_mode = LX_STRING;
                end
                LX_HALT: ;
                default: start_token(c);
            endcase
        end
        for (int i = 0; i < step_count; i++) begin
            step_tokens[i].last = (i == step_count - 1);
            tokens_due.insert(tokens_due.size(), step_tokens[i]);
        end
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    function void check_token();
        token_t want;
        if (tokens_due.size() == 0) begin
            $error("token with no expectation: kind %0d, first_char %0d, length %0d",
                   m_axis_tuser, m_axis_tdata[10:3], m_axis_tdata[34:19]);
            errors++;
            return;
        end
        want = tokens_due.pop_front();
        check_field("kind", want.kind, m_axis_tuser);
        check_field("keyword_index", want.kw_idx, m_axis_tdata[2:0]);
        check_field("first_char", want.c1, m_axis_tdata[10:3]);
        check_field("second_char", want.c2, m_axis_tdata[18:11]);
        check_field("length", want.len, m_axis_tdata[34:19]);
        check_field("last", want.last, m_axis_tlast);
        checked++;
    endfunction

    initial begin
        errors  = 0;
        checked = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            lex_mode = LX_IDLE;
            text_len = '0;
            cmp_char = '0;
            for (int i = 0; i < PREFIX_LEN; i++) begin
                text_head[i] = '0;
            end
            tokens_due.delete();
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                lex_step(s_axis_tdata, s_axis_tlast);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                check_token();
            end
        end
        fail_count     <= errors;
        tokens_pending <= tokens_due.size();
        tokens_checked <= checked;
    end

endmodule

[test/tb_source_lexer_tokenizer_core.sv]
`timescale 1ns / 100ps
// testbench top: drives source text into the lexer and reports the checker's verdict
module tb_source_lexer_tokenizer_core;
    import sltc_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int ITEM_TARGET  = 1700;
    localparam int TAIL_CYCLES  = 20;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tlast = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;
    logic                   m_axis_tlast;

    int fail_count;
    int tokens_pending;
    int tokens_checked;

    int send_gap_max = 6;
    int recv_stall_max = 6;
    int stall_left = 0;
    int idle_cycles = 0;
    int bytes_sent = 0;
    int marks_sent = 0;

    always #1 aclk = ~aclk;

    source_lexer_tokenizer_core u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    lexer_token_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tlast   (s_axis_tlast),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .m_axis_tlast   (m_axis_tlast),
        .fail_count     (fail_count),
        .tokens_pending (tokens_pending),
        .tokens_checked (tokens_checked)
    );

    // token receiver with a random stall after each transaction
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            stall_left = $urandom_range(0, recv_stall_max);
            m_axis_tready <= (stall_left == 0);
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_axis_tready <= (stall_left == 0);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles = idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic send_item(logic [7:0] c, logic eoi);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= eoi;
        do @(posedge aclk); while (!s_axis_tready);
        if (eoi) begin
            marks_sent++;
        end else begin
            bytes_sent++;
        end
    endtask

    task automatic send_byte(logic [7:0] c);
        send_item(c, 1'b0);
    endtask

    task automatic send_mark();
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i]);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (tokens_pending != 0);
    endtask

    function automatic logic [7:0] letter_byte();
        int r;
        r = $urandom_range(0, 51);
        return r < 26 ? 8'("a" + r) : 8'("A" + r - 26);
    endfunction

    function automatic logic [7:0] digit_byte();
        return 8'("0" + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE || b == CH_BSL);
        return b;
    endfunction

    task automatic send_keyword();
        case ($urandom_range(0, 7))
            0: send_text("if");
            1: send_text("else");
            2: send_text("for");
            3: send_text("while");
            4: send_text("do");
            5: send_text("int");
            6: send_text("read");
            default: send_text("write");
        endcase
    endtask

    task automatic send_comment_body(int n);
        logic [7:0] prev;
        logic [7:0] b;
        prev = 8'd0;
        repeat (n) begin
            b = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 3) == 0) begin
                b = CH_STAR;
            end
            if (prev == CH_STAR && b == CH_SLASH) begin
                b = "x";
            end
            send_byte(b);
            prev = b;
        end
    endtask

    task automatic send_string_body(int n);
        repeat (n) begin
            if ($urandom_range(0, 6) == 0) begin
                send_byte(CH_BSL);
                send_byte(8'($urandom_range(0, 255)));
            end else begin
                send_byte(plain_byte());
            end
        end
    endtask

    task automatic send_token();
        string ops;
        string cmps;
        int    r;
        ops  = "+-*(){};,:";
        cmps = "><=!";
        r = $urandom_range(0, 99);
        if (r < 18) begin
            send_keyword();
        end else if (r < 32) begin
            send_byte(letter_byte());
            repeat ($urandom_range(0, 7)) begin
                send_byte($urandom_range(0, 2) == 0 ? digit_byte() : letter_byte());
            end
        end else if (r < 44) begin
            repeat ($urandom_range(1, 6)) send_byte(digit_byte());
        end else if (r < 56) begin
            send_byte(ops[$urandom_range(0, 9)]);
        end else if (r < 64) begin
            send_byte(cmps[$urandom_range(0, 3)]);
            if ($urandom_range(0, 1) == 1) begin
                send_byte(CH_EQ);
            end
        end else if (r < 68) begin
            send_byte(CH_SLASH);
        end else if (r < 74) begin
            send_text("/*");
            send_comment_body($urandom_range(0, 8));
            send_text("*/");
        end else if (r < 84) begin
            send_byte(CH_QUOTE);
            send_string_body($urandom_range(0, 8));
            send_byte(CH_QUOTE);
        end else if (r < 94) begin
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(0, 2))
                    0: send_byte(CH_SPACE);
                    1: send_byte(CH_TAB);
                    default: send_byte(CH_NL);
                endcase
            end
        end else if (r < 97) begin
            send_byte(8'($urandom_range(0, 255)));
        end else begin
            send_mark();
        end
    endtask

    // a run of tokens, sometimes left with an open string or comment, then end of source
    task automatic send_chunk();
        int r;
        repeat ($urandom_range(1, 12)) send_token();
        r = $urandom_range(0, 9);
        if (r == 0) begin
            send_byte(CH_QUOTE);
            send_string_body($urandom_range(0, 3));
            if ($urandom_range(0, 1) == 1) begin
                send_byte(CH_BSL);
            end
        end else if (r == 1) begin
            send_text("/*");
            send_comment_body($urandom_range(0, 4));
        end
        send_mark();
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // keyword, comparison with '=', number ended by a string, escape, open string at end
        send_text("while>=9\"a\\\"");
        send_mark();
        // comparison ended by a word, word ended by a slash, lone slash flushed
        send_text("!x/");
        send_mark();
        send_mark();
        send_byte(8'hff);
        send_byte("a");
        send_mark();
        send_byte(CH_NUL);
        send_mark();
        send_text("\"\"/*");
        send_mark();
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            send_gap_max   = (phase == 1 || phase == 3) ? 0 : 6;
            recv_stall_max <= (phase >= 2) ? 0 : 6;
            while (bytes_sent + marks_sent < 25 + (ITEM_TARGET / 4) * (phase + 1)) begin
                send_chunk();
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("summary: %0d source bytes and %0d end-of-source marks sent, %0d tokens %s",
                 bytes_sent, marks_sent, tokens_checked, "compared");
        $display("summary: directed cases plus random token runs under four idle patterns");
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/sltc_pkg.sv
rtl/source_lexer_tokenizer_core.sv
rtl/sltc_checker.sv
test/lexer_token_checker.sv
test/tb_source_lexer_tokenizer_core.sv
